[hw/rtl/pscs_pkg.sv]
// ----------------------------------------------------------------------------
// pscs_pkg
// Shared types and codes for the packed small counter store.
// ----------------------------------------------------------------------------
package pscs_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DEC   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_WIDE  = 2'd2;
  localparam logic [1:0] STAT_UNDER = 2'd3;

  // Entry width modes.
  localparam logic [1:0] MODE_4BIT = 2'd0;
  localparam logic [1:0] MODE_6BIT = 2'd1;
  localparam logic [1:0] MODE_8BIT = 2'd2;

  // Configuration register indexes.
  localparam logic REG_WIDTH_MODE  = 1'b0;
  localparam logic REG_ENTRY_COUNT = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } pscs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } pscs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } pscs_stat_t;

endpackage

[hw/rtl/pscs_ram.sv]
// ----------------------------------------------------------------------------
// pscs_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module pscs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle: write when enabled, read every cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pscs_ctrl.sv]
// ----------------------------------------------------------------------------
// pscs_ctrl
// Controller: clearing pass, request handshake and result valid.
// ----------------------------------------------------------------------------
module pscs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pscs_pkg::pscs_stat_t stat_i,
  output pscs_pkg::pscs_cmd_t  cmd_o
);

  pscs_pkg::pscs_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  ready;

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pscs_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pscs_pkg::ST_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = pscs_pkg::ST_IDLE;
        end
      end
      pscs_pkg::ST_IDLE: begin
        if (in_valid_i && ready) begin
          state_d = pscs_pkg::ST_EXEC;
        end
      end
      pscs_pkg::ST_EXEC: begin
        state_d = pscs_pkg::ST_IDLE;
      end
      default: begin
        state_d = pscs_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs. A new word is taken once the result register is free or is
  // being drained in the same cycle.
  always_comb begin
    ready         = 1'b0;
    cmd_o.clear   = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      pscs_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      pscs_pkg::ST_IDLE: begin
        ready        = !out_valid_q || out_ready_i;
        cmd_o.accept = in_valid_i && ready;
      end
      pscs_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  // Result valid is set when a request finishes and dropped when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = ready;
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/pscs_datapath.sv]
// ----------------------------------------------------------------------------
// pscs_datapath
// Configuration, two byte banks, entry extract, checks and write-back.
// ----------------------------------------------------------------------------
module pscs_datapath #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [12:0]          cfg_wdata_i,
  input  logic [1:0]           in_kind_i,
  input  logic [11:0]          in_index_i,
  input  logic [7:0]           in_write_value_i,
  output logic [7:0]           out_read_value_o,
  output logic [1:0]           out_status_o,
  input  pscs_pkg::pscs_cmd_t  cmd_i,
  output pscs_pkg::pscs_stat_t stat_o
);

  // Even bytes live in bank 0 and odd bytes in bank 1, so a straddling
  // six-bit entry reaches both of its bytes in one access.
  localparam int Rows = (MAX_ENTRIES + 1) / 2;
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

  logic [1:0]      width_mode_q;
  logic [12:0]     entry_count_q;
  logic [RowW-1:0] clr_q;
  logic [1:0]      kind_q;
  logic [11:0]     idx_q;
  logic [7:0]      wval_q;
  logic            in_range_q;
  logic            a0_q;
  logic [2:0]      sh_q;
  logic [RowW-1:0] row0_q, row1_q;
  logic [7:0]      rval_q, rval_d;
  logic [1:0]      stat_q, stat_d;

  logic [14:0]     off;
  logic [11:0]     a_in;
  logic [2:0]      sh_in;
  logic [RowW-1:0] row0_in, row1_in;
  logic            in_range;
  logic [RowW-1:0] addr0, addr1;
  logic [7:0]      rd0, rd1, wd0, wd1;
  logic            we0, we1;
  logic [7:0]      lo, hi, cur, nv, limit, new_lo, new_hi;
  logic [15:0]     w16, w_sh, mask, w2;
  logic            do_write, hi_we;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q  <= pscs_pkg::MODE_8BIT;
      entry_count_q <= 13'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == pscs_pkg::REG_WIDTH_MODE) begin
        width_mode_q <= cfg_wdata_i[1:0];
      end else begin
        entry_count_q <= cfg_wdata_i;
      end
    end
  end

  // Clearing pass row counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + RowW'(1);
    end
  end
  assign stat_o.clear_last = (clr_q == RowW'(Rows - 1));

  // Byte address of the low byte of the addressed entry.
  assign off = {1'b0, in_index_i, 2'b00} + {2'b00, in_index_i, 1'b0};
  always_comb begin
    sh_in = off[2:0];
    case (width_mode_q)
      pscs_pkg::MODE_4BIT: a_in = {1'b0, in_index_i[11:1]};
      pscs_pkg::MODE_6BIT: a_in = off[14:3];
      default:             a_in = in_index_i;
    endcase
  end
  assign row0_in  = RowW'({1'b0, a_in[11:1]} + {11'd0, a_in[0]});
  assign row1_in  = RowW'(a_in[11:1]);
  assign in_range = ({1'b0, in_index_i} < entry_count_q) &&
                    (32'(in_index_i) < 32'(MAX_ENTRIES));

  // Request capture at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q     <= in_kind_i;
      idx_q      <= in_index_i;
      wval_q     <= in_write_value_i;
      in_range_q <= in_range;
      a0_q       <= a_in[0];
      sh_q       <= sh_in;
      row0_q     <= row0_in;
      row1_q     <= row1_in;
    end
  end

  // Bank addresses: clearing sweep, write-back, or read for a new word.
  always_comb begin
    if (cmd_i.clear) begin
      addr0 = clr_q;
      addr1 = clr_q;
    end else if (cmd_i.exec) begin
      addr0 = row0_q;
      addr1 = row1_q;
    end else begin
      addr0 = row0_in;
      addr1 = row1_in;
    end
  end

  pscs_ram #(.WIDTH(8), .DEPTH(Rows)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .addr_i  (addr0),
    .wdata_i (wd0),
    .rdata_o (rd0)
  );

  pscs_ram #(.WIDTH(8), .DEPTH(Rows)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .addr_i  (addr1),
    .wdata_i (wd1),
    .rdata_o (rd1)
  );

  // Entry extract from the low and high bytes.
  assign lo   = a0_q ? rd1 : rd0;
  assign hi   = a0_q ? rd0 : rd1;
  assign w16  = {hi, lo};
  assign w_sh = w16 >> sh_q;
  always_comb begin
    case (width_mode_q)
      pscs_pkg::MODE_4BIT: begin
        cur   = idx_q[0] ? {4'd0, lo[7:4]} : {4'd0, lo[3:0]};
        limit = 8'd15;
      end
      pscs_pkg::MODE_6BIT: begin
        cur   = {2'd0, w_sh[5:0]};
        limit = 8'd63;
      end
      default: begin
        cur   = lo;
        limit = 8'd255;
      end
    endcase
  end

  // Checks in order: index, then value width or underflow.
  always_comb begin
    rval_d   = 8'd0;
    stat_d   = pscs_pkg::STAT_OK;
    do_write = 1'b0;
    nv       = wval_q;
    if (kind_q <= pscs_pkg::KIND_DEC) begin
      if (!in_range_q) begin
        stat_d = pscs_pkg::STAT_RANGE;
      end else begin
        case (kind_q)
          pscs_pkg::KIND_READ: begin
            rval_d = cur;
          end
          pscs_pkg::KIND_WRITE: begin
            if (wval_q > limit) begin
              stat_d = pscs_pkg::STAT_WIDE;
            end else begin
              do_write = 1'b1;
            end
          end
          default: begin
            if (cur == 8'd0) begin
              stat_d = pscs_pkg::STAT_UNDER;
            end else begin
              do_write = 1'b1;
              nv       = cur - 8'd1;
            end
          end
        endcase
      end
    end
  end

  // Merge the new value into the bytes it occupies.
  assign mask = 16'h003f << sh_q;
  assign w2   = (w16 & ~mask) | (16'(nv[5:0]) << sh_q);
  always_comb begin
    new_hi = hi;
    hi_we  = 1'b0;
    case (width_mode_q)
      pscs_pkg::MODE_4BIT: begin
        new_lo = idx_q[0] ? {nv[3:0], lo[3:0]} : {lo[7:4], nv[3:0]};
      end
      pscs_pkg::MODE_6BIT: begin
        new_lo = w2[7:0];
        new_hi = w2[15:8];
        hi_we  = (sh_q > 3'd2);
      end
      default: begin
        new_lo = nv;
      end
    endcase
  end

  // Bank write enables and data; the clearing sweep writes zeros.
  always_comb begin
    if (cmd_i.clear) begin
      we0 = 1'b1;
      we1 = 1'b1;
      wd0 = 8'd0;
      wd1 = 8'd0;
    end else begin
      we0 = cmd_i.exec && do_write && (a0_q ? hi_we : 1'b1);
      we1 = cmd_i.exec && do_write && (a0_q ? 1'b1 : hi_we);
      wd0 = a0_q ? new_hi : new_lo;
      wd1 = a0_q ? new_lo : new_hi;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rval_q <= rval_d;
      stat_q <= stat_d;
    end
  end

  assign out_read_value_o = rval_q;
  assign out_status_o     = stat_q;

endmodule

[hw/rtl/packed_small_counter_store.sv]
// ----------------------------------------------------------------------------
// packed_small_counter_store
// Array of 4, 6 or 8 bit counters packed into a byte store.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (kind, index, write value) with a
// valid/ready handshake; each word yields exactly one result word on the
// out_ channel (read value, status). Width mode and entry count are set
// through the plain write port; the user must write them only while no
// request is in flight, and the block itself does not enforce this. The
// cycle a request is accepted reads both byte banks, and the next cycle
// checks, writes back and loads the result register. The result is valid
// the cycle after that, and a new word is taken only after the previous
// one is written back. The limit is the single port of each byte bank,
// used once to read and once to write. After reset the store is cleared
// one even/odd byte pair per cycle through all (MAX_ENTRIES + 1) / 2 rows;
// in_ready_o stays low meanwhile and configuration writes are still taken.
// While the receiver stalls the result holds and no new word is taken;
// a word is taken in the same cycle the pending result is drained.
// ----------------------------------------------------------------------------
module packed_small_counter_store #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_kind_i,
  input  logic [11:0] in_index_i,
  input  logic [7:0]  in_write_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_read_value_o,
  output logic [1:0]  out_status_o
);

  pscs_pkg::pscs_cmd_t  cmd;
  pscs_pkg::pscs_stat_t stat;

  // Controller.
  pscs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath with the byte store.
  pscs_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_kind_i        (in_kind_i),
    .in_index_i       (in_index_i),
    .in_write_value_i (in_write_value_i),
    .out_read_value_o (out_read_value_o),
    .out_status_o     (out_status_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the packed small counter store.
// ----------------------------------------------------------------------------
// Request words are driven on the input channel and every result word is
// compared, field by field, against a behavioral copy of the store that is
// updated in acceptance order. A short directed part covers each width
// mode, the status codes and their check order, the unused kind and mode,
// the entry count clamp and reinterpretation after a mode change. The
// random part then runs under several sender and receiver idle patterns,
// reconfiguring between segments while the block is drained.
// ----------------------------------------------------------------------------
module tb;

  localparam int          STORE_BYTES = 4096;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          REPORT_CAP  = 50;
  localparam logic [1:0]  KIND_NONE   = 2'd3;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
  } result_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic        cfg_index_i      = 1'b0;
  logic [12:0] cfg_wdata_i      = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  in_kind_i        = '0;
  logic [11:0] in_index_i       = '0;
  logic [7:0]  in_write_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [7:0]  out_read_value_o;
  logic [1:0]  out_status_o;

  // Behavioral copy of the store and its configuration.
  logic [7:0]  store_bytes [STORE_BYTES];
  logic [1:0]  cur_mode  = pscs_pkg::MODE_8BIT;
  logic [12:0] cur_count = '0;

  result_t     pending_results [$];
  int          mismatches   = 0;
  int          cycle_count  = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;

  packed_small_counter_store #(
    .MAX_ENTRIES(STORE_BYTES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_kind_i       (in_kind_i),
    .in_index_i      (in_index_i),
    .in_write_value_i(in_write_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_read_value_o(out_read_value_o),
    .out_status_o    (out_status_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Largest value an entry holds in the current mode.
  function automatic logic [7:0] entry_limit();
    case (cur_mode)
      pscs_pkg::MODE_4BIT: entry_limit = 8'd15;
      pscs_pkg::MODE_6BIT: entry_limit = 8'd63;
      default:             entry_limit = 8'd255;
    endcase
  endfunction

  // Number of entries in use, clamped to the store size.
  function automatic int entries_in_use();
    entries_in_use = (int'(cur_count) > STORE_BYTES) ? STORE_BYTES : int'(cur_count);
  endfunction

  function automatic logic [7:0] counter_read(input logic [11:0] idx);
    int unsigned offset;
    logic [15:0] pair;
    case (cur_mode)
      pscs_pkg::MODE_4BIT: begin
        if (idx[0]) counter_read = {4'h0, store_bytes[idx >> 1][7:4]};
        else        counter_read = {4'h0, store_bytes[idx >> 1][3:0]};
      end
      pscs_pkg::MODE_6BIT: begin
        // Six-bit entries are packed from the LSB and may span two bytes.
        offset = 6 * int'(idx);
        pair   = {store_bytes[offset / 8 + 1], store_bytes[offset / 8]};
        counter_read = 8'(pair >> (offset % 8)) & 8'h3f;
      end
      default: counter_read = store_bytes[idx];
    endcase
  endfunction

  function automatic void counter_write(input logic [11:0] idx, input logic [7:0] value);
    int unsigned offset;
    int unsigned shift;
    logic [15:0] pair;
    case (cur_mode)
      pscs_pkg::MODE_4BIT: begin
        if (idx[0]) store_bytes[idx >> 1][7:4] = value[3:0];
        else        store_bytes[idx >> 1][3:0] = value[3:0];
      end
      pscs_pkg::MODE_6BIT: begin
        offset = 6 * int'(idx);
        shift  = offset % 8;
        pair   = {store_bytes[offset / 8 + 1], store_bytes[offset / 8]};
        pair   = (pair & ~(16'h003f << shift)) | (16'(value[5:0]) << shift);
        store_bytes[offset / 8] = pair[7:0];
        if (shift > 2) store_bytes[offset / 8 + 1] = pair[15:8];
      end
      default: store_bytes[idx] = value;
    endcase
  endfunction

  // Apply one request to the store copy and return the result it earns.
  // The index is checked first, then the write value or the zero counter.
  function automatic result_t apply_request(input logic [1:0] kind, input logic [11:0] idx,
                                            input logic [7:0] wval);
    result_t    res;
    logic [7:0] current;
    res = '{read_value: 8'd0, status: pscs_pkg::STAT_OK};
    if (kind != KIND_NONE) begin
      if (int'(idx) >= entries_in_use()) begin
        res.status = pscs_pkg::STAT_RANGE;
      end else if (kind == pscs_pkg::KIND_READ) begin
        res.read_value = counter_read(idx);
      end else if (kind == pscs_pkg::KIND_WRITE) begin
        if (wval > entry_limit()) res.status = pscs_pkg::STAT_WIDE;
        else counter_write(idx, wval);
      end else begin
        current = counter_read(idx);
        if (current == 8'd0) res.status = pscs_pkg::STAT_UNDER;
        else counter_write(idx, current - 8'd1);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers and result checking
  // ---------------------------------------------------------------------------

  // Receiver: ready is redrawn every cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected result word: expected none, got value %0d status %0d",
                   $time, out_read_value_o, out_status_o);
      end else begin
        want = pending_results.pop_front();
        if (out_read_value_o !== want.read_value) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: read value mismatch: expected %0d, got %0d",
                     $time, want.read_value, out_read_value_o);
        end
        if (out_status_o !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_status_o);
        end
      end
    end
  end

  // Send one request word and record the result it should produce.
  task automatic send_word(input logic [1:0] kind, input logic [11:0] idx,
                           input logic [7:0] wval);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_kind_i        <= kind;
    in_index_i       <= idx;
    in_write_value_i <= wval;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_request(kind, idx, wval));
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Register write, done only while the block is idle.
  task automatic write_register(input logic reg_index, input logic [12:0] data);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= reg_index;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (reg_index == pscs_pkg::REG_WIDTH_MODE) cur_mode = data[1:0];
    else cur_count = data;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset no entry is in use, so every request is out of range.
  task automatic test_reset_state();
    send_word(pscs_pkg::KIND_READ, 12'd0, 8'd0);
    send_word(pscs_pkg::KIND_DEC, 12'hfff, 8'hff);
  endtask

  // Eight-bit entries: extremes, decrement, underflow and the unused kind.
  task automatic test_eight_bit();
    write_register(pscs_pkg::REG_WIDTH_MODE, 13'(pscs_pkg::MODE_8BIT));
    write_register(pscs_pkg::REG_ENTRY_COUNT, 13'd4096);
    send_word(pscs_pkg::KIND_WRITE, 12'd0, 8'd255);
    send_word(pscs_pkg::KIND_READ, 12'd0, 8'd0);
    send_word(pscs_pkg::KIND_DEC, 12'd0, 8'd0);
    send_word(pscs_pkg::KIND_READ, 12'd0, 8'd0);
    send_word(pscs_pkg::KIND_WRITE, 12'hfff, 8'd0);
    send_word(pscs_pkg::KIND_DEC, 12'hfff, 8'd0);
    send_word(pscs_pkg::KIND_READ, 12'hfff, 8'd0);
    send_word(KIND_NONE, 12'd0, 8'haa);
  endtask

  // Four-bit entries: value too wide, nibble placement, range before width.
  task automatic test_four_bit();
    write_register(pscs_pkg::REG_WIDTH_MODE, 13'(pscs_pkg::MODE_4BIT));
    write_register(pscs_pkg::REG_ENTRY_COUNT, 13'd16);
    send_word(pscs_pkg::KIND_WRITE, 12'd1, 8'd16);
    send_word(pscs_pkg::KIND_WRITE, 12'd1, 8'd15);
    send_word(pscs_pkg::KIND_WRITE, 12'd0, 8'd5);
    send_word(pscs_pkg::KIND_READ, 12'd1, 8'd0);
    send_word(pscs_pkg::KIND_WRITE, 12'd16, 8'd255);
  endtask

  // Six-bit entries: an entry across a byte boundary, and old bytes
  // reinterpreted under the new layout.
  task automatic test_six_bit();
    write_register(pscs_pkg::REG_WIDTH_MODE, 13'(pscs_pkg::MODE_6BIT));
    write_register(pscs_pkg::REG_ENTRY_COUNT, 13'd4096);
    send_word(pscs_pkg::KIND_READ, 12'd0, 8'd0);
    send_word(pscs_pkg::KIND_WRITE, 12'd1, 8'd63);
    send_word(pscs_pkg::KIND_WRITE, 12'd2, 8'd64);
    send_word(pscs_pkg::KIND_READ, 12'd1, 8'd0);
    send_word(pscs_pkg::KIND_WRITE, 12'hfff, 8'd42);
  endtask

  // Unused mode acts as eight-bit; an oversized count is clamped; a count
  // of zero puts every index out of range.
  task automatic test_spare_mode_and_counts();
    write_register(pscs_pkg::REG_WIDTH_MODE, 13'(MODE_SPARE));
    write_register(pscs_pkg::REG_ENTRY_COUNT, 13'h1fff);
    send_word(pscs_pkg::KIND_READ, 12'hfff, 8'd0);
    send_word(pscs_pkg::KIND_WRITE, 12'hfff, 8'd200);
    write_register(pscs_pkg::REG_ENTRY_COUNT, 13'd0);
    send_word(pscs_pkg::KIND_READ, 12'd0, 8'd0);
  endtask

  // One random request, mostly in range with values that fit.
  task automatic random_word();
    logic [1:0]  kind;
    logic [11:0] idx;
    logic [7:0]  wval;
    int          pick;
    int          used;
    used = entries_in_use();
    pick = $urandom_range(99);
    if (pick < 30)      kind = pscs_pkg::KIND_READ;
    else if (pick < 60) kind = pscs_pkg::KIND_WRITE;
    else if (pick < 94) kind = pscs_pkg::KIND_DEC;
    else                kind = KIND_NONE;
    if (used > 0 && $urandom_range(99) < 85) idx = 12'($urandom_range(used - 1));
    else idx = 12'($urandom_range(4095));
    case ($urandom_range(3))
      0:       wval = 8'($urandom_range(3));
      3:       wval = 8'($urandom_range(255));
      default: wval = 8'($urandom_range(int'(entry_limit())));
    endcase
    send_word(kind, idx, wval);
  endtask

  // Random traffic under each idle pattern, reconfigured between segments.
  task automatic test_random_traffic();
    int sender_pct [4];
    int receiver_pct [4];
    int phase;
    int seg;
    int n;
    logic [12:0] count;
    sender_pct   = '{0, 80, 0, 37};
    receiver_pct = '{0, 0, 80, 37};
    for (phase = 0; phase < 4; phase++) begin
      for (seg = 0; seg < 3; seg++) begin
        write_register(pscs_pkg::REG_WIDTH_MODE, 13'((phase * 3 + seg) % 4));
        case ($urandom_range(3))
          0:       count = 13'($urandom_range(48, 1));
          1:       count = 13'd4096;
          2:       count = 13'($urandom_range(8191, 4097));
          default: count = 13'($urandom_range(4096, 1));
        endcase
        write_register(pscs_pkg::REG_ENTRY_COUNT, count);
        send_idle_pct = sender_pct[phase];
        stall_pct     = receiver_pct[phase];
        for (n = 0; n < 70; n++) begin
          // Runs with no idling on either side.
          if (n == 40 && phase == 3) begin
            send_idle_pct = 0;
            stall_pct     = 0;
          end
          random_word();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    end
  endtask

  // Main sequence.
  initial begin
    for (int i = 0; i < STORE_BYTES; i++) store_bytes[i] = 8'd0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_eight_bit();
    test_four_bit();
    test_six_bit();
    test_spare_mode_and_counts();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
